FILE: hw/rtl/rpfa_pkg.sv
// ----------------------------------------------------------------------------
// rpfa_pkg
// Shared codes and types for the reference-counted page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpfa_pkg;

   localparam int CMD_W    = 3;
   localparam int FRAME_W  = 16;
   localparam int END_W    = 17;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_REF   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MARK_FREE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MARK_USED = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RMW,
      ST_MARK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rpfa_ram.sv
// ----------------------------------------------------------------------------
// rpfa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/refcounted_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator
// 8-bit reference count per page frame held in one RAM; alloc, free and
// add-ref run as read-modify-write sequences, range marking as plain writes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | cmd, frame, range_end
//  rsp     | out       | rsp_valid/stall   | status, result_frame, new_count
//
//  free, add-ref, empty range, other commands: read, write (free and add-ref when the count changes), respond
//  out-of-table frame: check, respond
//  alloc: scan from frame 0 to the first free frame, write it, respond; out of memory: scan the whole table, respond
//  mark range: one RAM write a cycle from frame up to the clipped end, then respond
//  after reset the RAM is cleared, one entry a cycle, with req stalled
//  one beat in flight; a stalled response holds the next beat in the respond step
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_page_frame_allocator #(
   parameter int NUM_FRAMES = 65536
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [rpfa_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [rpfa_pkg::FRAME_W-1:0]   req_frame,
   input  wire logic [rpfa_pkg::END_W-1:0]     req_range_end,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [rpfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [rpfa_pkg::FRAME_W-1:0]   rsp_result_frame,
   output logic      [rpfa_pkg::COUNT_W-1:0]   rsp_new_count
);

   localparam int AW = $clog2(NUM_FRAMES);
   localparam int CW = (AW + 1 > rpfa_pkg::END_W) ? AW + 1 : rpfa_pkg::END_W;
   localparam logic [AW-1:0] LAST_FRAME = AW'(NUM_FRAMES - 1);
   localparam logic [CW-1:0] NUM_EXT    = CW'(NUM_FRAMES);

   rpfa_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                   ptr_ff, ptr_in;
   logic [AW-1:0]                   last_ff, last_in;
   logic [rpfa_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [rpfa_pkg::FRAME_W-1:0]    frame_ff, frame_in;
   logic [rpfa_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [rpfa_pkg::FRAME_W-1:0]    res_frame_ff, res_frame_in;
   logic [rpfa_pkg::COUNT_W-1:0]    res_count_ff, res_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rpfa_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [rpfa_pkg::FRAME_W-1:0]    rsp_frame_ff, rsp_frame_in;
   logic [rpfa_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                            ram_wr_en;
   logic [AW-1:0]                   ram_wr_addr;
   logic [rpfa_pkg::COUNT_W-1:0]    ram_wr_data;
   logic                            ram_rd_en;
   logic [AW-1:0]                   ram_rd_addr;
   logic [rpfa_pkg::COUNT_W-1:0]    ram_rd_data;

   logic [CW-1:0]                   frame_ext;
   logic [CW-1:0]                   end_ext;
   logic [CW-1:0]                   end_clip;
   logic                            frame_ok;
   logic                            range_ok;
   logic [AW-1:0]                   req_addr;
   logic [rpfa_pkg::COUNT_W-1:0]    mark_val;

   assign frame_ext = CW'(req_frame);
   assign end_ext   = CW'(req_range_end);
   assign end_clip  = (end_ext < NUM_EXT) ? end_ext : NUM_EXT;
   assign frame_ok  = frame_ext < NUM_EXT;
   assign range_ok  = end_clip > frame_ext;
   assign req_addr  = AW'(req_frame);
   assign mark_val  = (cmd_ff == rpfa_pkg::CMD_MARK_USED) ? 8'd1 : 8'd0;

   rpfa_ram #(
      .WIDTH (rpfa_pkg::COUNT_W),
      .DEPTH (NUM_FRAMES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      last_in       = last_ff;
      cmd_in        = cmd_ff;
      frame_in      = frame_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ptr_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ptr_ff;
      req_stall     = 1'b1;

      case (state_ff)
         rpfa_pkg::ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (ptr_ff == LAST_FRAME) begin
               ptr_in   = '0;
               state_in = rpfa_pkg::ST_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end

         rpfa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in        = req_cmd;
               frame_in      = req_frame;
               res_status_in = rpfa_pkg::STATUS_OK;
               res_frame_in  = req_frame;
               res_count_in  = '0;
               case (req_cmd)
                  rpfa_pkg::CMD_ALLOC: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     ptr_in      = '0;
                     state_in    = rpfa_pkg::ST_SCAN;
                  end
                  rpfa_pkg::CMD_FREE, rpfa_pkg::CMD_ADD_REF: begin
                     if (frame_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_addr;
                        state_in    = rpfa_pkg::ST_RMW;
                     end else begin
                        res_status_in = rpfa_pkg::STATUS_RANGE;
                        state_in      = rpfa_pkg::ST_RESP;
                     end
                  end
                  rpfa_pkg::CMD_MARK_FREE, rpfa_pkg::CMD_MARK_USED: begin
                     if (!frame_ok) begin
                        res_status_in = rpfa_pkg::STATUS_RANGE;
                        state_in      = rpfa_pkg::ST_RESP;
                     end else if (range_ok) begin
                        ptr_in   = req_addr;
                        last_in  = AW'(end_clip - CW'(1));
                        state_in = rpfa_pkg::ST_MARK;
                     end else begin
                        // empty range, just report the current count
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_addr;
                        state_in    = rpfa_pkg::ST_RMW;
                     end
                  end
                  default: begin
                     if (frame_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_addr;
                        state_in    = rpfa_pkg::ST_RMW;
                     end else begin
                        state_in = rpfa_pkg::ST_RESP;
                     end
                  end
               endcase
            end
         end

         rpfa_pkg::ST_SCAN: begin
            if (ram_rd_data == '0) begin
               ram_wr_en    = 1'b1;
               ram_wr_data  = 8'd1;
               res_frame_in = rpfa_pkg::FRAME_W'(ptr_ff);
               res_count_in = 8'd1;
               state_in     = rpfa_pkg::ST_RESP;
            end else if (ptr_ff == LAST_FRAME) begin
               res_status_in = rpfa_pkg::STATUS_OOM;
               res_frame_in  = '0;
               state_in      = rpfa_pkg::ST_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff + AW'(1);
               ptr_in      = ptr_ff + AW'(1);
            end
         end

         rpfa_pkg::ST_RMW: begin
            ram_wr_addr  = AW'(frame_ff);
            res_count_in = ram_rd_data;
            case (cmd_ff)
               rpfa_pkg::CMD_FREE: begin
                  if (ram_rd_data != '0) begin
                     ram_wr_en    = 1'b1;
                     ram_wr_data  = ram_rd_data - 8'd1;
                     res_count_in = ram_rd_data - 8'd1;
                  end
               end
               rpfa_pkg::CMD_ADD_REF: begin
                  if (ram_rd_data == rpfa_pkg::COUNT_MAX) begin
                     res_status_in = rpfa_pkg::STATUS_SATURATED;
                  end else begin
                     ram_wr_en    = 1'b1;
                     ram_wr_data  = ram_rd_data + 8'd1;
                     res_count_in = ram_rd_data + 8'd1;
                  end
               end
               default: begin
               end
            endcase
            state_in = rpfa_pkg::ST_RESP;
         end

         rpfa_pkg::ST_MARK: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = mark_val;
            if (ptr_ff == last_ff) begin
               res_count_in = mark_val;
               state_in     = rpfa_pkg::ST_RESP;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end

         rpfa_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_frame_in  = res_frame_ff;
               rsp_count_in  = res_count_ff;
               state_in      = rpfa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rpfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpfa_pkg::ST_CLEAR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff       <= last_in;
      cmd_ff        <= cmd_in;
      frame_ff      <= frame_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_frame = rsp_frame_ff;
   assign rsp_new_count    = rsp_count_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rpfa_checker.sv
// ----------------------------------------------------------------------------
// rpfa_checker
// Port-level checks for the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfa_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [rpfa_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [rpfa_pkg::FRAME_W-1:0]   rsp_result_frame,
   input wire logic [rpfa_pkg::COUNT_W-1:0]   rsp_new_count
);

   // a stalled response beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_frame) && $stable(rsp_new_count))
      else $error("stalled response beat changed");

   // one beat in flight: an accepted request closes the input side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while one is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rpfa_pkg::STATUS_OOM |->
         rsp_result_frame == '0 && rsp_new_count == '0)
      else $error("out of memory beat carries a frame or count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rpfa_pkg::STATUS_SATURATED |->
         rsp_new_count == rpfa_pkg::COUNT_MAX)
      else $error("saturated beat without full count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rpfa_pkg::STATUS_RANGE |-> rsp_new_count == '0)
      else $error("out of range beat carries a count");

endmodule

bind refcounted_page_frame_allocator rpfa_checker u_rpfa_checker (.*);

`default_nettype wire

FILE: sim/refcounted_page_frame_allocator_test.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_test
// Self-checking bench for the page frame allocator. A directed set covers
// alloc up to out of memory, free at zero, add-ref saturation, frames at the
// top of the table, empty and clipped ranges and the spare command codes. Random
// sequences of allocs, frees, add-refs and range marks follow. Both sides
// idle and stall in bursts. Every reply is checked against a predictor that
// keeps its own count table.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_page_frame_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rpfa_pkg::*;

   localparam int unsigned FRAMES         = 65536;
   localparam int unsigned STREAM_BEATS   = 820;
   localparam int unsigned QUIET_TAIL     = 100;
   localparam int unsigned WATCHDOG_LIMIT = 10 * FRAMES + 1000;
   localparam int unsigned END_MAX        = 2 ** END_W - 1;
   localparam int unsigned FRAME_MAX      = 2 ** FRAME_W - 1;
   localparam int unsigned CMD_MAX        = 2 ** CMD_W - 1;

   localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [FRAME_W-1:0] frame;
      logic [END_W-1:0]   range_end;
      bit                 drain;
   } page_request_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  frame;
      logic [COUNT_W-1:0]  count;
   } page_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [FRAME_W-1:0]  req_frame = '0;
   logic [END_W-1:0]    req_range_end = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [FRAME_W-1:0]  rsp_result_frame;
   logic [COUNT_W-1:0]  rsp_new_count;

   logic [COUNT_W-1:0] frame_count [FRAMES];
   page_request_type   pending_beats [$];
   page_reply_type     expected_replies [$];

   int unsigned mismatches = 0;
   int unsigned replies_seen = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned idle_cycles = 0;
   bit          req_fire = 1'b0;
   bit          quiet = 1'b0;

   refcounted_page_frame_allocator #(
      .NUM_FRAMES(FRAMES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_frame       (req_frame),
      .req_range_end   (req_range_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_frame(rsp_result_frame),
      .rsp_new_count   (rsp_new_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < FRAMES; i++) begin
         frame_count[i[FRAME_W-1:0]] = '0;
      end
   end

   function automatic page_reply_type apply_request(page_request_type r);
      page_reply_type rep;
      int unsigned stop;
      int unsigned i;
      bit          found;
      bit          in_table;
      rep.status = STATUS_OK;
      rep.frame  = r.frame;
      rep.count  = '0;
      in_table   = r.frame < FRAMES;
      found      = 1'b0;
      case (r.cmd)
         CMD_ALLOC: begin
            rep.frame = '0;
            for (i = 0; i < FRAMES && !found; i++) begin
               if (frame_count[i[FRAME_W-1:0]] == '0) begin
                  found                       = 1'b1;
                  frame_count[i[FRAME_W-1:0]] = 8'd1;
                  rep.frame                   = i[FRAME_W-1:0];
                  rep.count                   = 8'd1;
               end
            end
            if (!found) begin
               rep.status = STATUS_OOM;
            end
         end
         CMD_FREE: begin
            if (!in_table) begin
               rep.status = STATUS_RANGE;
            end else begin
               if (frame_count[r.frame] != '0) begin
                  frame_count[r.frame] = frame_count[r.frame] - 8'd1;
               end
               rep.count = frame_count[r.frame];
            end
         end
         CMD_ADD_REF: begin
            if (!in_table) begin
               rep.status = STATUS_RANGE;
            end else begin
               if (frame_count[r.frame] == COUNT_MAX) begin
                  rep.status = STATUS_SATURATED;
               end else begin
                  frame_count[r.frame] = frame_count[r.frame] + 8'd1;
               end
               rep.count = frame_count[r.frame];
            end
         end
         CMD_MARK_FREE, CMD_MARK_USED: begin
            if (!in_table) begin
               rep.status = STATUS_RANGE;
            end else begin
               stop = (r.range_end > FRAMES) ? FRAMES : r.range_end;
               for (i = r.frame; i < stop; i++) begin
                  frame_count[i[FRAME_W-1:0]] = (r.cmd == CMD_MARK_USED) ? 8'd1 : 8'd0;
               end
               rep.count = frame_count[r.frame];
            end
         end
         default: begin
            if (in_table) begin
               rep.count = frame_count[r.frame];
            end
         end
      endcase
      return rep;
   endfunction

   function automatic void queue_beat(logic [CMD_W-1:0] cmd, int unsigned frame,
                                      int unsigned range_end, bit drain = 1'b0);
      page_request_type r;
      r.cmd       = cmd;
      r.frame     = frame[FRAME_W-1:0];
      r.range_end = range_end[END_W-1:0];
      r.drain     = drain;
      pending_beats.push_back(r);
   endfunction

   // mostly the low frames where allocs land, now and then anywhere
   function automatic int unsigned target_frame();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         return $urandom_range(0, 63);
      end else if (pick < 9) begin
         return $urandom_range(0, FRAMES - 1);
      end
      return $urandom_range(0, FRAME_MAX);
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned wanted);
      mismatches++;
      $display("reply %0d: %s got %0d expected %0d", replies_seen, what, got, wanted);
   endtask

   // request side: predict on acceptance
   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         expected_replies.push_back(apply_request('{req_cmd, req_frame, req_range_end,
                                                    1'b0}));
      end
      quiet = pending_beats.size() < QUIET_TAIL;
   end

   always @(negedge clock) begin : feed_requests
      page_request_type nxt;
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (pending_beats.size() != 0 &&
                      (!pending_beats[0].drain || expected_replies.size() == 0)) begin
            nxt = pending_beats.pop_front();
            req_cmd       <= nxt.cmd;
            req_frame     <= nxt.frame;
            req_range_end <= nxt.range_end;
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && !quiet && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_replies
      page_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         replies_seen++;
         if (expected_replies.size() == 0) begin
            report_mismatch("reply with none pending, status", 32'(rsp_status), 0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
            if (rsp_result_frame !== want.frame) begin
               report_mismatch("result_frame", 32'(rsp_result_frame), 32'(want.frame));
            end
            if (rsp_new_count !== want.count) begin
               report_mismatch("new_count", 32'(rsp_new_count), 32'(want.count));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
                     idle_cycles, expected_replies.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned kind;
      int unsigned n;
      int unsigned f;
      int unsigned len;
      bit          hold;
      logic [CMD_W-1:0] mark_cmd;

      // directed beats
      queue_beat(CMD_ALLOC, 0, 0);
      queue_beat(CMD_ALLOC, 0, 0);
      queue_beat(CMD_ADD_REF, 0, 0);
      queue_beat(CMD_FREE, 0, 0);
      queue_beat(CMD_FREE, 1, 0);
      queue_beat(CMD_FREE, 1, 0);
      queue_beat(CMD_FREE, FRAME_MAX, 0);
      queue_beat(CMD_ADD_REF, FRAME_MAX, END_MAX);
      queue_beat(CMD_MARK_USED, FRAME_MAX, END_MAX);
      queue_beat(CMD_MARK_USED, 2, 2);
      queue_beat(CMD_MARK_FREE, 10, 5);
      queue_beat(CMD_SPARE_5, 0, 0);
      queue_beat(CMD_SPARE_6, FRAME_MAX, END_MAX);
      queue_beat(CMD_SPARE_7, FRAMES - 1, 0);
      queue_beat(CMD_MARK_USED, 0, 'h10000);
      queue_beat(CMD_ALLOC, 0, 0);
      queue_beat(CMD_MARK_FREE, FRAMES - 1, END_MAX);
      queue_beat(CMD_ALLOC, 0, 0);
      queue_beat(CMD_ALLOC, 0, 0);
      queue_beat(CMD_MARK_FREE, 0, FRAMES);
      queue_beat(CMD_ADD_REF, FRAMES - 1, 0);
      queue_beat(CMD_FREE, FRAMES, 0);
      queue_beat(CMD_MARK_FREE, FRAMES, FRAMES + 4);
      queue_beat(CMD_ALLOC, 0, 0);

      // drive one frame into saturation, after a full drain
      f = $urandom_range(0, FRAMES - 1);
      queue_beat(CMD_ADD_REF, f, 0, 1'b1);
      repeat (259) queue_beat(CMD_ADD_REF, f, 0);
      queue_beat(CMD_FREE, f, 0);
      queue_beat(CMD_MARK_FREE, f, f + 1);

      while (pending_beats.size() < STREAM_BEATS) begin
         kind = $urandom_range(0, 9);
         hold = $urandom_range(0, 19) == 0;
         case (kind)
            0, 1, 2: begin
               n = $urandom_range(1, 8);
               queue_beat(CMD_ALLOC, $urandom_range(0, FRAME_MAX), 0, hold);
               repeat (n - 1) queue_beat(CMD_ALLOC, 0, $urandom_range(0, END_MAX));
            end
            3, 4: begin
               n = $urandom_range(1, 6);
               queue_beat(CMD_FREE, target_frame(), 0, hold);
               repeat (n - 1) queue_beat(CMD_FREE, target_frame(), 0);
            end
            5: begin
               f = target_frame();
               n = $urandom_range(1, 6);
               queue_beat(CMD_ADD_REF, f, 0, hold);
               repeat (n - 1) queue_beat(CMD_ADD_REF, f, 0);
               queue_beat(CMD_FREE, f, 0);
            end
            6: begin
               f = $urandom_range(0, FRAMES - 1);
               len = $urandom_range(0, 40);
               mark_cmd = $urandom_range(0, 1) ? CMD_MARK_USED : CMD_MARK_FREE;
               queue_beat(mark_cmd, f, f + len, hold);
               queue_beat(CMD_ALLOC, 0, 0);
            end
            7: begin
               if ($urandom_range(0, 2) == 0) begin
                  // fill the table, run out, then free a stretch
                  queue_beat(CMD_MARK_USED, 0, $urandom_range(FRAMES, END_MAX), hold);
                  queue_beat(CMD_ALLOC, 0, 0);
                  queue_beat(CMD_ADD_REF, $urandom_range(0, FRAMES - 1), 0);
                  f = $urandom_range(0, FRAMES - 1);
                  queue_beat(CMD_MARK_FREE, f, f + $urandom_range(1, 64));
                  queue_beat(CMD_ALLOC, 0, 0);
                  queue_beat(CMD_ALLOC, 0, 0);
               end else begin
                  mark_cmd = $urandom_range(0, 1) ? CMD_MARK_USED : CMD_MARK_FREE;
                  queue_beat(mark_cmd, $urandom_range(0, FRAMES - 1),
                             $urandom_range(0, END_MAX), hold);
               end
            end
            default: begin
               n = $urandom_range(1, 4);
               queue_beat(CMD_W'($urandom_range(0, CMD_MAX)), $urandom_range(0, FRAME_MAX),
                          $urandom_range(0, END_MAX), hold);
               repeat (n - 1) begin
                  queue_beat(CMD_W'($urandom_range(0, CMD_MAX)),
                             $urandom_range(0, FRAME_MAX), $urandom_range(0, END_MAX));
               end
            end
         endcase
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      // let a long scan or range mark settle so stray replies show up
      repeat (FRAMES + 16) @(posedge clock);

      if (mismatches == 0 && expected_replies.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
